// File: sv/pmr_pkg.sv
// Shared constants for the posterior mean rate block: field widths,
// register map codes and reset values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pmr_pkg;

   localparam int DEF_MAX_CATEGORIES = 4;
   localparam int DEF_LH_BITS        = 32;

   localparam int RATE_BITS     = 16;   // Q4.12 rate and mean
   localparam int QUOT_BITS     = RATE_BITS;
   localparam int COUNT_BITS    = 3;
   localparam int BEST_BITS     = 2;
   localparam int RSP_DATA_BITS = 24;   // mean_rate + best_category, padded to bytes
   localparam int CSR_DATA_BITS = 32;

   localparam logic [COUNT_BITS-1:0] COUNT_RESET = 3'd4;
   localparam logic [RATE_BITS-1:0]  RATE_RESET  = 16'd4096;

   // register indexes (byte address / 4)
   localparam int REG_COUNT     = 0;
   localparam int REG_RATE_BASE = 1;

endpackage

`default_nettype wire

// File: sv/posterior_mean_rate_and_best_category.sv
// Posterior mean rate and best category, one site pattern per transfer.
// Pipeline: 18 register stages (lane products, merge, 16 restoring division
// stages, one quotient bit each); rsp_tvalid rises once a pattern leaves the last.
// Throughput: one pattern per cycle while rsp_tready is high; the pipeline collapses bubbles on stall.
// Reset: synchronous; empties the pipeline, category_count = 4, rates = 1.0.
`timescale 1ns / 1ps
`default_nettype none

module posterior_mean_rate_and_best_category #(
   parameter int MAX_CATEGORIES = pmr_pkg::DEF_MAX_CATEGORIES,
   parameter int LH_BITS        = pmr_pkg::DEF_LH_BITS,
   localparam int REQ_BITS  = ((MAX_CATEGORIES * LH_BITS + 7) / 8) * 8,
   localparam int ADDR_BITS = $clog2(4 * (MAX_CATEGORIES + 1))
) (
   input  logic                              clock,
   input  logic                              reset,
   // lh_cat_0 .. lh_cat_N, LH_BITS each, lowest first
   input  logic [REQ_BITS-1:0]               req_tdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [15:0] mean_rate, [17:16] best_category, rest zero
   output logic [pmr_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // [0] sum_zero
   output logic                              rsp_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ADDR_BITS-1:0]              csr_paddr,
   input  logic [pmr_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [pmr_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);
   import pmr_pkg::*;

   localparam int SUM_BITS  = LH_BITS + $clog2(MAX_CATEGORIES);
   localparam int NUM_BITS  = SUM_BITS + RATE_BITS;
   localparam int PROD_BITS = RATE_BITS + LH_BITS;
   localparam int IDX_BITS  = $clog2(MAX_CATEGORIES);
   localparam int NSTG      = 2 + QUOT_BITS;
   localparam int REG_BITS  = ADDR_BITS - 2;

   // ---------------- configuration registers ----------------
   logic [COUNT_BITS-1:0]                     count_ff;
   logic [MAX_CATEGORIES-1:0][RATE_BITS-1:0]  rate_ff;
   logic [REG_BITS-1:0]                       reg_idx;
   logic                                      csr_wr;

   assign reg_idx    = csr_paddr[ADDR_BITS-1:2];
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
         for (int c = 0; c < MAX_CATEGORIES; c++) rate_ff[c] <= RATE_RESET;
      end else if (csr_wr) begin
         if (reg_idx == REG_BITS'(REG_COUNT)) count_ff <= csr_pwdata[COUNT_BITS-1:0];
         for (int c = 0; c < MAX_CATEGORIES; c++) begin
            if (reg_idx == REG_BITS'(REG_RATE_BASE + c))
               rate_ff[c] <= csr_pwdata[RATE_BITS-1:0];
         end
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_idx == REG_BITS'(REG_COUNT)) csr_prdata = CSR_DATA_BITS'(count_ff);
      for (int c = 0; c < MAX_CATEGORIES; c++) begin
         if (reg_idx == REG_BITS'(REG_RATE_BASE + c))
            csr_prdata = CSR_DATA_BITS'(rate_ff[c]);
      end
   end

   // ---------------- pipeline control ----------------
   logic [NSTG-1:0] valid_ff, valid_in;
   logic [NSTG:0]   ready;

   always_comb begin
      ready[NSTG] = rsp_tready;
      for (int k = NSTG - 1; k >= 0; k--) ready[k] = !valid_ff[k] || ready[k+1];
      for (int k = 0; k < NSTG; k++) begin
         if (ready[k]) valid_in[k] = (k == 0) ? req_tvalid : valid_ff[(k == 0) ? 0 : k-1];
         else          valid_in[k] = valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else       valid_ff <= valid_in;
   end

   assign req_tready = ready[0];
   assign rsp_tvalid = valid_ff[NSTG-1];

   // ---------------- lanes ----------------
   logic [MAX_CATEGORIES-1:0]                lane_on;
   logic [MAX_CATEGORIES-1:0][PROD_BITS-1:0] lane_prod;
   logic [MAX_CATEGORIES-1:0][LH_BITS-1:0]   lane_lh;

   // zero count runs lane 0 alone; counts above the lane count run all
   always_comb begin
      for (int c = 0; c < MAX_CATEGORIES; c++)
         lane_on[c] = (c == 0) || (int'(count_ff) > c);
   end

   for (genvar c = 0; c < MAX_CATEGORIES; c++) begin : g_lane
      pmr_lane #(.LH_BITS(LH_BITS)) u_lane (
         .clock   (clock),
         .load    (ready[0]),
         .lane_on (lane_on[c]),
         .rate    (rate_ff[c]),
         .lh      (req_tdata[c*LH_BITS +: LH_BITS]),
         .prod    (lane_prod[c]),
         .lh_used (lane_lh[c])
      );
   end

   // ---------------- merge ----------------
   logic [NUM_BITS-1:0] num;
   logic [SUM_BITS-1:0] den;
   logic [IDX_BITS-1:0] best;
   logic                zero;

   pmr_merge #(.MAX_CATEGORIES(MAX_CATEGORIES), .LH_BITS(LH_BITS)) u_merge (
      .clock (clock),
      .load  (ready[1]),
      .prod  (lane_prod),
      .lh    (lane_lh),
      .num   (num),
      .den   (den),
      .best  (best),
      .zero  (zero)
   );

   // ---------------- division pipeline ----------------
   logic [QUOT_BITS:0][NUM_BITS-1:0] work_s;
   logic [QUOT_BITS:0][SUM_BITS-1:0] den_s;
   logic [QUOT_BITS:0][IDX_BITS-1:0] best_s;
   logic [QUOT_BITS:0]               zero_s;

   assign work_s[0] = num;
   assign den_s[0]  = den;
   assign best_s[0] = best;
   assign zero_s[0] = zero;

   for (genvar j = 0; j < QUOT_BITS; j++) begin : g_div
      pmr_div_stage #(.SUM_BITS(SUM_BITS), .IDX_BITS(IDX_BITS)) u_div (
         .clock  (clock),
         .load   (ready[2+j]),
         .work_i (work_s[j]),
         .den_i  (den_s[j]),
         .best_i (best_s[j]),
         .zero_i (zero_s[j]),
         .work_o (work_s[j+1]),
         .den_o  (den_s[j+1]),
         .best_o (best_s[j+1]),
         .zero_o (zero_s[j+1])
      );
   end

   // the remainder and divisor leaving the last stage are not needed
   logic [RATE_BITS-1:0] mean;
   logic                 rem_any;

   assign rem_any = |{work_s[QUOT_BITS][NUM_BITS-1:QUOT_BITS], den_s[QUOT_BITS]};
   assign mean    = (zero_s[QUOT_BITS] || (rem_any && 1'b0)) ? '0
                                                             : work_s[QUOT_BITS][RATE_BITS-1:0];
   assign rsp_tdata = RSP_DATA_BITS'({BEST_BITS'(best_s[QUOT_BITS]), mean});
   assign rsp_tuser = zero_s[QUOT_BITS];

endmodule

`default_nettype wire

// File: sv/pmr_lane.sv
// One category lane: registered rate * likelihood product and masked likelihood.
// Depends on pmr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pmr_lane #(
   parameter int LH_BITS = pmr_pkg::DEF_LH_BITS
) (
   input  logic                                 clock,
   input  logic                                 load,
   input  logic                                 lane_on,
   input  logic [pmr_pkg::RATE_BITS-1:0]        rate,
   input  logic [LH_BITS-1:0]                   lh,
   output logic [pmr_pkg::RATE_BITS+LH_BITS-1:0] prod,
   output logic [LH_BITS-1:0]                   lh_used
);
   import pmr_pkg::*;

   localparam int PROD_BITS = RATE_BITS + LH_BITS;

   logic [PROD_BITS-1:0] prod_ff, prod_in;
   logic [LH_BITS-1:0]   lh_ff, lh_in;

   // unused lanes contribute nothing to either sum and never win the max
   always_comb begin
      prod_in = '0;
      lh_in   = '0;
      if (lane_on) begin
         prod_in = rate * lh;
         lh_in   = lh;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
         lh_ff   <= lh_in;
      end
   end

   assign prod    = prod_ff;
   assign lh_used = lh_ff;

endmodule

`default_nettype wire

// File: sv/pmr_merge.sv
// Merge stage: sums lane products and likelihoods, picks the best lane.
// Depends on pmr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pmr_merge #(
   parameter int MAX_CATEGORIES = pmr_pkg::DEF_MAX_CATEGORIES,
   parameter int LH_BITS        = pmr_pkg::DEF_LH_BITS,
   localparam int SUM_BITS  = LH_BITS + $clog2(MAX_CATEGORIES),
   localparam int NUM_BITS  = SUM_BITS + pmr_pkg::RATE_BITS,
   localparam int PROD_BITS = pmr_pkg::RATE_BITS + LH_BITS,
   localparam int IDX_BITS  = $clog2(MAX_CATEGORIES)
) (
   input  logic                                     clock,
   input  logic                                     load,
   input  logic [MAX_CATEGORIES-1:0][PROD_BITS-1:0] prod,
   input  logic [MAX_CATEGORIES-1:0][LH_BITS-1:0]   lh,
   output logic [NUM_BITS-1:0]                      num,
   output logic [SUM_BITS-1:0]                      den,
   output logic [IDX_BITS-1:0]                      best,
   output logic                                     zero
);
   import pmr_pkg::*;

   logic [NUM_BITS-1:0] num_ff, num_in;
   logic [SUM_BITS-1:0] den_ff, den_in;
   logic [IDX_BITS-1:0] best_ff, best_in;
   logic                zero_ff;
   logic [LH_BITS-1:0]  best_lh;

   always_comb begin
      num_in  = '0;
      den_in  = '0;
      best_in = '0;
      best_lh = lh[0];
      for (int c = 0; c < MAX_CATEGORIES; c++) begin
         num_in = num_in + NUM_BITS'(prod[c]);
         den_in = den_in + SUM_BITS'(lh[c]);
      end
      // strict greater: lowest index keeps ties
      for (int c = 1; c < MAX_CATEGORIES; c++) begin
         if (lh[c] > best_lh) begin
            best_lh = lh[c];
            best_in = IDX_BITS'(c);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         num_ff  <= num_in;
         den_ff  <= den_in;
         best_ff <= best_in;
         zero_ff <= (den_in == '0);
      end
   end

   assign num  = num_ff;
   assign den  = den_ff;
   assign best = best_ff;
   assign zero = zero_ff;

endmodule

`default_nettype wire

// File: sv/pmr_div_stage.sv
// One registered step of restoring division: one quotient bit per stage.
// The quotient bits shift into the low end as numerator bits leave it.
// Depends on pmr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pmr_div_stage #(
   parameter int SUM_BITS = pmr_pkg::DEF_LH_BITS + 2,
   parameter int IDX_BITS = 2,
   localparam int WORK_BITS = SUM_BITS + pmr_pkg::QUOT_BITS
) (
   input  logic                 clock,
   input  logic                 load,
   input  logic [WORK_BITS-1:0] work_i,
   input  logic [SUM_BITS-1:0]  den_i,
   input  logic [IDX_BITS-1:0]  best_i,
   input  logic                 zero_i,
   output logic [WORK_BITS-1:0] work_o,
   output logic [SUM_BITS-1:0]  den_o,
   output logic [IDX_BITS-1:0]  best_o,
   output logic                 zero_o
);
   import pmr_pkg::*;

   logic [WORK_BITS-1:0] work_ff, work_in;
   logic [SUM_BITS-1:0]  den_ff;
   logic [IDX_BITS-1:0]  best_ff;
   logic                 zero_ff;
   logic [SUM_BITS:0]    trial;
   logic [SUM_BITS:0]    diff;
   logic                 fits;

   // upper SUM_BITS hold the partial remainder, always below den
   always_comb begin
      trial   = work_i[WORK_BITS-1:QUOT_BITS-1];
      diff    = trial - {1'b0, den_i};
      fits    = (trial >= {1'b0, den_i});
      work_in = {(fits ? diff[SUM_BITS-1:0] : trial[SUM_BITS-1:0]),
                 work_i[QUOT_BITS-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (load) begin
         work_ff <= work_in;
         den_ff  <= den_i;
         best_ff <= best_i;
         zero_ff <= zero_i;
      end
   end

   assign work_o = work_ff;
   assign den_o  = den_ff;
   assign best_o = best_ff;
   assign zero_o = zero_ff;

endmodule

`default_nettype wire

// File: sv/pmr_checker.sv
// Port-level checks on the posterior mean rate block, bound to the top level.
// Depends on pmr_pkg and posterior_mean_rate_and_best_category.
`timescale 1ns / 1ps
`default_nettype none

module pmr_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [pmr_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input  wire logic                              rsp_tuser,
   input  wire logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic                              csr_pready
);
   import pmr_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp changed while stalled");

   // all-zero likelihoods force mean 0 and category 0
   a_zero_mean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[RATE_BITS+BEST_BITS-1:0] == '0)
      else $error("sum_zero result with nonzero mean or category");

   // pad bits above best_category stay zero
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_BITS-1:RATE_BITS+BEST_BITS] == '0)
      else $error("rsp_tdata pad bits set");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid after reset");

   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("csr_pready low");

endmodule

bind posterior_mean_rate_and_best_category pmr_checker u_pmr_checker (.*);

`default_nettype wire
